[design/pidci_pkg.sv]
// shared types, codes and constants of the pid controller with conditional integration
package pidci_pkg;

  // one input request
  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [23:0] measured;
    logic signed [23:0] setpoint;
    logic signed [23:0] external_rate;
  } in_req_t;

  // one result request
  typedef struct packed {
    logic signed [23:0] drive;
    logic               limit_hit;
  } out_req_t;

  // command codes
  localparam logic [1:0] CMD_STEP  = 2'd0;
  localparam logic [1:0] CMD_REARM = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_KP        = 3'd0;
  localparam logic [2:0] REG_KI        = 3'd1;
  localparam logic [2:0] REG_KD        = 3'd2;
  localparam logic [2:0] REG_PERIOD    = 3'd3;
  localparam logic [2:0] REG_RATE      = 3'd4;
  localparam logic [2:0] REG_OUT_LIM   = 3'd5;
  localparam logic [2:0] REG_RATE_SEL  = 3'd6;
  localparam logic [2:0] REG_REARM_LIM = 3'd7;

  // register reset values
  localparam logic [15:0] PERIOD_RST = 16'd655;
  localparam logic [15:0] RATE_RST   = 16'd100;
  localparam logic [22:0] LIMIT_RST  = 23'd8388607;

  // bounds of the drive and of each gain term
  localparam logic signed [63:0] DRIVE_MAX = 64'sd8388607;
  localparam logic signed [63:0] DRIVE_MIN = -64'sd8388608;
  localparam logic [95:0]        TERM_CAP  = 96'd1 << 60;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LO,
    ST_HI,
    ST_FIN,
    ST_IADD,
    ST_SUM,
    ST_LIMIT,
    ST_MISC,
    ST_DONE
  } state_t;

  // multiply operations run on the shared unit
  typedef enum logic [2:0] {
    OP_INC,
    OP_DER,
    OP_P,
    OP_I,
    OP_D
  } op_t;

endpackage

[design/pid_with_conditional_integration.sv]
// pid controller step with conditional integration over one shared multiplier
//
//   channel  | direction | handshake              | payload
//   in_      | input     | in_valid / in_stall    | pidci_pkg::in_req_t
//   out_     | output    | out_valid / out_stall  | pidci_pkg::out_req_t
//   apb      | input     | psel penable pwrite    | paddr[4:0], pwdata/prdata[31:0]
//
// A control step runs five multiplies from acceptance to the result register, four when the
// derivative comes from the external rate, each with load, low half, high half and finish
// steps on one 32x32 multiplier, plus integral add, two sum steps and result hand-off.
// Rearm, clear and the unused command take one misc step and the result hand-off.
// Reset is synchronous and active low; it zeroes the controller state and loads
// register defaults. A stalled result waits in the output register while the next
// request is taken; the sequencer holds only if that register is still full at the end.
module pid_with_conditional_integration #(
  parameter int INTEGRAL_WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pidci_pkg::in_req_t   in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output pidci_pkg::out_req_t  out_data,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int IntW = INTEGRAL_WIDTH;
  localparam int SumW = ((IntW > 42) ? IntW : 42) + 1;
  localparam logic signed [SumW-1:0] IntHi =
    {{(SumW-IntW+1){1'b0}}, {(IntW-1){1'b1}}};
  localparam logic signed [SumW-1:0] IntLo = ~IntHi;

  // configuration registers
  logic signed [31:0] kp_r, ki_r, kd_r;
  logic        [15:0] period_r, rate_r;
  logic        [22:0] out_lim_r, rearm_lim_r;
  logic               rate_sel_r;

  // controller state
  logic signed [IntW-1:0] integral_r, before_r;
  logic signed [23:0]     prev_input_r, prev_setpoint_r, prev_drive_r;

  // sequencer
  pidci_pkg::state_t state_r, state_nxt;
  pidci_pkg::op_t    op_r, op_nxt;

  // latched request
  logic        [1:0]  cmd_r;
  logic signed [23:0] meas_r, setp_r, ext_r;
  logic signed [24:0] err_r, diff_r;

  // shared multiplier unit
  logic        [63:0] mul_a_r;
  logic        [31:0] mul_b_r;
  logic               neg_r;
  logic        [95:0] acc_r;
  logic        [31:0] mul_half;
  logic        [63:0] pp;

  // intermediate terms
  logic signed [41:0] inc_r, deriv_r;
  logic signed [61:0] up_r, ui_r, ud_r;
  logic signed [62:0] pd_r;

  // result staging and output register
  logic signed [23:0] res_drive_r;
  logic               res_hit_r;
  logic               out_valid_r;
  pidci_pkg::out_req_t out_data_r;

  logic in_acc, cfg_wr, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || !out_stall;
  assign pready   = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      period_r    <= pidci_pkg::PERIOD_RST;
      rate_r      <= pidci_pkg::RATE_RST;
      out_lim_r   <= pidci_pkg::LIMIT_RST;
      rate_sel_r  <= 1'b0;
      rearm_lim_r <= pidci_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        pidci_pkg::REG_KP:        kp_r        <= pwdata;
        pidci_pkg::REG_KI:        ki_r        <= pwdata;
        pidci_pkg::REG_KD:        kd_r        <= pwdata;
        pidci_pkg::REG_PERIOD:    period_r    <= pwdata[15:0];
        pidci_pkg::REG_RATE:      rate_r      <= pwdata[15:0];
        pidci_pkg::REG_OUT_LIM:   out_lim_r   <= pwdata[22:0];
        pidci_pkg::REG_RATE_SEL:  rate_sel_r  <= pwdata[0];
        pidci_pkg::REG_REARM_LIM: rearm_lim_r <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[4:2])
      pidci_pkg::REG_KP:        prdata = kp_r;
      pidci_pkg::REG_KI:        prdata = ki_r;
      pidci_pkg::REG_KD:        prdata = kd_r;
      pidci_pkg::REG_PERIOD:    prdata = {16'd0, period_r};
      pidci_pkg::REG_RATE:      prdata = {16'd0, rate_r};
      pidci_pkg::REG_OUT_LIM:   prdata = {9'd0, out_lim_r};
      pidci_pkg::REG_RATE_SEL:  prdata = {31'd0, rate_sel_r};
      pidci_pkg::REG_REARM_LIM: prdata = {9'd0, rearm_lim_r};
      default:                  prdata = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidci_pkg::ST_IDLE;
      op_r    <= pidci_pkg::OP_INC;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    in_stall  = (state_r != pidci_pkg::ST_IDLE);
    case (state_r)
      pidci_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == pidci_pkg::CMD_STEP) begin
            state_nxt = pidci_pkg::ST_LOAD;
            op_nxt    = pidci_pkg::OP_INC;
          end else begin
            state_nxt = pidci_pkg::ST_MISC;
          end
        end
      end
      pidci_pkg::ST_LOAD: state_nxt = pidci_pkg::ST_LO;
      pidci_pkg::ST_LO:   state_nxt = pidci_pkg::ST_HI;
      pidci_pkg::ST_HI:   state_nxt = pidci_pkg::ST_FIN;
      pidci_pkg::ST_FIN: begin
        case (op_r)
          pidci_pkg::OP_INC: state_nxt = pidci_pkg::ST_IADD;
          pidci_pkg::OP_DER: begin
            state_nxt = pidci_pkg::ST_LOAD;
            op_nxt    = pidci_pkg::OP_P;
          end
          pidci_pkg::OP_P: begin
            state_nxt = pidci_pkg::ST_LOAD;
            op_nxt    = pidci_pkg::OP_I;
          end
          pidci_pkg::OP_I: begin
            state_nxt = pidci_pkg::ST_LOAD;
            op_nxt    = pidci_pkg::OP_D;
          end
          default: state_nxt = pidci_pkg::ST_SUM;
        endcase
      end
      pidci_pkg::ST_IADD: begin
        state_nxt = pidci_pkg::ST_LOAD;
        op_nxt    = rate_sel_r ? pidci_pkg::OP_P : pidci_pkg::OP_DER;
      end
      pidci_pkg::ST_SUM:   state_nxt = pidci_pkg::ST_LIMIT;
      pidci_pkg::ST_LIMIT: state_nxt = pidci_pkg::ST_DONE;
      pidci_pkg::ST_MISC:  state_nxt = pidci_pkg::ST_DONE;
      pidci_pkg::ST_DONE: begin
        if (out_free) state_nxt = pidci_pkg::ST_IDLE;
      end
      default: state_nxt = pidci_pkg::ST_IDLE;
    endcase
  end

  // operand select for the multiplier load
  logic signed [63:0] a_sel;
  logic signed [32:0] b_sel;
  logic        [63:0] a_mag;
  logic        [32:0] b_mag;
  logic               der_neg;

  always_comb begin
    case (op_r)
      pidci_pkg::OP_INC: begin
        a_sel = 64'(err_r);
        b_sel = {17'd0, period_r};
      end
      pidci_pkg::OP_DER: begin
        a_sel = 64'(diff_r);
        b_sel = {17'd0, rate_r};
      end
      pidci_pkg::OP_P: begin
        a_sel = 64'(err_r);
        b_sel = 33'(kp_r);
      end
      pidci_pkg::OP_I: begin
        a_sel = 64'(integral_r);
        b_sel = 33'(ki_r);
      end
      default: begin
        a_sel = 64'(deriv_r);
        b_sel = 33'(kd_r);
      end
    endcase
    a_mag   = a_sel[63] ? (64'd0 - a_sel) : a_sel;
    b_mag   = b_sel[32] ? (33'd0 - b_sel) : b_sel;
    der_neg = (op_r == pidci_pkg::OP_DER);
  end

  // one 32x32 partial product a cycle
  assign mul_half = (state_r == pidci_pkg::ST_LO) ? mul_a_r[31:0] : mul_a_r[63:32];
  assign pp       = mul_half * mul_b_r;

  // finish: shift, cap at the term bound, apply sign
  logic [95:0] shifted;
  logic [60:0] capped;
  logic signed [61:0] fin_res;

  always_comb begin
    case (op_r)
      pidci_pkg::OP_P, pidci_pkg::OP_D: shifted = acc_r >> 16;
      pidci_pkg::OP_I:                  shifted = acc_r >> 32;
      default:                          shifted = acc_r;
    endcase
    capped  = (shifted > pidci_pkg::TERM_CAP) ? pidci_pkg::TERM_CAP[60:0] : shifted[60:0];
    fin_res = neg_r ? (62'd0 - {1'b0, capped}) : {1'b0, capped};
  end

  // saturating integral add
  logic signed [SumW-1:0] iadd_sum;
  logic signed [IntW-1:0] iadd_sat;

  always_comb begin
    iadd_sum = SumW'(integral_r) + SumW'(inc_r);
    if (iadd_sum > IntHi)      iadd_sat = IntHi[IntW-1:0];
    else if (iadd_sum < IntLo) iadd_sat = IntLo[IntW-1:0];
    else                       iadd_sat = iadd_sum[IntW-1:0];
  end

  // rearm value: last drive clamped, moved to integral format, saturated
  logic signed [24:0]     rlim, rclamp;
  logic signed [SumW-1:0] rearm_ext;
  logic signed [IntW-1:0] rearm_sat;

  always_comb begin
    rlim = $signed({2'b00, rearm_lim_r});
    if (25'(prev_drive_r) > rlim)       rclamp = rlim;
    else if (25'(prev_drive_r) < -rlim) rclamp = -rlim;
    else                                rclamp = 25'(prev_drive_r);
    rearm_ext = SumW'($signed({rclamp, 16'd0}));
    if (rearm_ext > IntHi)      rearm_sat = IntHi[IntW-1:0];
    else if (rearm_ext < IntLo) rearm_sat = IntLo[IntW-1:0];
    else                        rearm_sat = rearm_ext[IntW-1:0];
  end

  // final sum, limit check and drive clamp
  logic signed [63:0] full_sum, lim_s, pick;
  logic               hit;
  logic signed [23:0] drive_c;

  always_comb begin
    full_sum = 64'(pd_r) + 64'(ui_r);
    lim_s    = $signed({41'd0, out_lim_r});
    hit      = (full_sum > lim_s) || (full_sum < -lim_s);
    pick     = hit ? 64'(pd_r) : full_sum;
    if (pick > pidci_pkg::DRIVE_MAX)      drive_c = pidci_pkg::DRIVE_MAX[23:0];
    else if (pick < pidci_pkg::DRIVE_MIN) drive_c = pidci_pkg::DRIVE_MIN[23:0];
    else                                  drive_c = pick[23:0];
  end

  // sign flip of the reference against the last reference
  logic flip;
  assign flip = (in_data.setpoint > 24'sd0 && prev_setpoint_r < 24'sd0) ||
                (in_data.setpoint < 24'sd0 && prev_setpoint_r > 24'sd0);

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r      <= '0;
      prev_input_r    <= '0;
      prev_setpoint_r <= '0;
      prev_drive_r    <= '0;
    end else begin
      case (state_r)
        pidci_pkg::ST_IDLE: begin
          if (in_acc && in_data.cmd == pidci_pkg::CMD_STEP && flip) integral_r <= '0;
        end
        pidci_pkg::ST_IADD: integral_r <= iadd_sat;
        pidci_pkg::ST_LIMIT: begin
          if (hit) integral_r <= before_r;
          prev_drive_r    <= drive_c;
          prev_input_r    <= meas_r;
          prev_setpoint_r <= setp_r;
        end
        pidci_pkg::ST_MISC: begin
          if (cmd_r == pidci_pkg::CMD_REARM) begin
            prev_input_r <= meas_r;
            integral_r   <= rearm_sat;
          end else if (cmd_r == pidci_pkg::CMD_CLEAR) begin
            integral_r      <= '0;
            prev_input_r    <= '0;
            prev_setpoint_r <= '0;
            prev_drive_r    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      pidci_pkg::ST_IDLE: begin
        cmd_r  <= in_data.cmd;
        meas_r <= in_data.measured;
        setp_r <= in_data.setpoint;
        ext_r  <= in_data.external_rate;
        err_r  <= 25'(in_data.setpoint) - 25'(in_data.measured);
        diff_r <= 25'(in_data.measured) - 25'(prev_input_r);
      end
      pidci_pkg::ST_LOAD: begin
        mul_a_r <= a_mag;
        mul_b_r <= b_mag[31:0];
        neg_r   <= a_sel[63] ^ b_sel[32] ^ der_neg;
      end
      pidci_pkg::ST_LO: acc_r <= {32'd0, pp};
      pidci_pkg::ST_HI: acc_r <= acc_r + {pp, 32'd0};
      pidci_pkg::ST_FIN: begin
        case (op_r)
          pidci_pkg::OP_INC: inc_r   <= fin_res[41:0];
          pidci_pkg::OP_DER: deriv_r <= fin_res[41:0];
          pidci_pkg::OP_P:   up_r    <= fin_res;
          pidci_pkg::OP_I:   ui_r    <= fin_res;
          default:           ud_r    <= fin_res;
        endcase
      end
      pidci_pkg::ST_IADD: begin
        before_r <= integral_r;
        if (rate_sel_r) deriv_r <= 42'd0 - 42'(ext_r);
      end
      pidci_pkg::ST_SUM: pd_r <= 63'(up_r) + 63'(ud_r);
      pidci_pkg::ST_LIMIT: begin
        res_drive_r <= drive_c;
        res_hit_r   <= hit;
      end
      pidci_pkg::ST_MISC: begin
        res_drive_r <= (cmd_r == pidci_pkg::CMD_CLEAR) ? 24'sd0 : prev_drive_r;
        res_hit_r   <= 1'b0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == pidci_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pidci_pkg::ST_DONE && out_free) begin
      out_data_r.drive     <= res_drive_r;
      out_data_r.limit_hit <= res_hit_r;
    end
  end

endmodule

[design/pidci_checker.sv]
// port-level checks for the pid controller, bound to the top level
module pidci_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pidci_pkg::out_req_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // an accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took no time for a request");

  // a new result appears only at the end of busy work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

  // finishing work always leaves a result in the output register
  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("work finished without a result");

endmodule

bind pid_with_conditional_integration pidci_checker u_pidci_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/tb_pid_with_conditional_integration.sv]
// self-checking testbench for the pid step with conditional integration, predicted per request
module tb_pid_with_conditional_integration;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INTEGRAL_WIDTH = 48;
  localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint TERM_LIMIT = longint'(1) <<< 60;
  localparam longint DRIVE_TOP = 8388607;
  localparam longint DRIVE_BOTTOM = -8388608;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS = 1500;
  localparam int BLOCKS = 8;
  localparam int BLOCK_ITEMS = 185;
  localparam int WINDUP_PUSH = 150;
  localparam int REPORT_LIMIT = 10;

  // predicts each drive from accepted requests and checks the results in order
  class pid_step_tracker;
    logic signed [31:0] kp, ki, kd;
    logic [15:0] period, rate;
    logic [22:0] out_limit, rearm_limit;
    logic rate_sel;
    longint integ, last_input, last_setpoint, last_drive;
    pidci_pkg::out_req_t pending_drives[$];
    int mismatches, checked, hits, steps, rearms, clears, unused;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      period = pidci_pkg::PERIOD_RST;
      rate = pidci_pkg::RATE_RST;
      out_limit = pidci_pkg::LIMIT_RST;
      rearm_limit = pidci_pkg::LIMIT_RST;
      rate_sel = 1'b0;
      integ = 0;
      last_input = 0;
      last_setpoint = 0;
      last_drive = 0;
      mismatches = 0;
      checked = 0;
      hits = 0;
      steps = 0;
      rearms = 0;
      clears = 0;
      unused = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        pidci_pkg::REG_KP:        kp = value;
        pidci_pkg::REG_KI:        ki = value;
        pidci_pkg::REG_KD:        kd = value;
        pidci_pkg::REG_PERIOD:    period = value[15:0];
        pidci_pkg::REG_RATE:      rate = value[15:0];
        pidci_pkg::REG_OUT_LIM:   out_limit = value[22:0];
        pidci_pkg::REG_RATE_SEL:  rate_sel = value[0];
        pidci_pkg::REG_REARM_LIM: rearm_limit = value[22:0];
        default: ;
      endcase
    endfunction

    function longint bound(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // gain product shifted down, truncated toward zero, capped at 2^60
    function longint scaled_product(longint a, longint g, int sh);
      logic [127:0] mag;
      logic [63:0] ua, ug;
      bit neg;
      neg = (a < 0) != (g < 0);
      ua = (a < 0) ? -a : a;
      ug = (g < 0) ? -g : g;
      mag = ({64'd0, ua} * {64'd0, ug}) >> sh;
      if (mag > 128'(TERM_LIMIT)) mag = 128'(TERM_LIMIT);
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function void record_request(pidci_pkg::in_req_t req);
      longint y, r, ext, err, inc, held, deriv, up, ui, ud, total, lim;
      pidci_pkg::out_req_t res;
      y = $signed(req.measured);
      r = $signed(req.setpoint);
      ext = $signed(req.external_rate);
      res.drive = last_drive[23:0];
      res.limit_hit = 1'b0;
      case (req.cmd)
        pidci_pkg::CMD_STEP: begin
          steps++;
          // reference crossing zero against the last one restarts the integral
          if ((r > 0 && last_setpoint < 0) || (r < 0 && last_setpoint > 0)) integ = 0;
          err = r - y;
          inc = longint'(period) * err;
          held = integ;
          // saturating integration
          if (inc > 0 && integ > INTEG_MAX - inc) integ = INTEG_MAX;
          else if (inc < 0 && integ < INTEG_MIN - inc) integ = INTEG_MIN;
          else integ = integ + inc;
          deriv = rate_sel ? -ext : -((y - last_input) * longint'(rate));
          up = scaled_product(err, kp, 16);
          ui = scaled_product(integ, ki, 32);
          ud = scaled_product(deriv, kd, 16);
          total = up + ui + ud;
          lim = longint'(out_limit);
          // over the bound: undo this integration and drop the i term
          if (total > lim || total < -lim) begin
            integ = held;
            total = up + ud;
            res.limit_hit = 1'b1;
            hits++;
          end
          last_drive = bound(total, DRIVE_BOTTOM, DRIVE_TOP);
          last_input = y;
          last_setpoint = r;
          res.drive = last_drive[23:0];
        end
        pidci_pkg::CMD_REARM: begin
          rearms++;
          lim = longint'(rearm_limit);
          last_input = y;
          integ = bound(bound(last_drive, -lim, lim) * 65536, INTEG_MIN, INTEG_MAX);
        end
        pidci_pkg::CMD_CLEAR: begin
          clears++;
          integ = 0;
          last_input = 0;
          last_setpoint = 0;
          last_drive = 0;
          res.drive = '0;
        end
        default: unused++;
      endcase
      pending_drives.push_back(res);
    endfunction

    function void check_result(pidci_pkg::out_req_t got);
      pidci_pkg::out_req_t want;
      checked++;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result with nothing pending: drive %0d limit_hit %0b",
                   $time, got.drive, got.limit_hit);
        return;
      end
      want = pending_drives.pop_front();
      if (got.drive !== want.drive || got.limit_hit !== want.limit_hit) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result %0d: drive exp %0d got %0d, limit_hit exp %0b got %0b",
                   $time, checked, want.drive, got.drive, want.limit_hit, got.limit_hit);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pidci_pkg::in_req_t in_data;
  logic out_valid;
  logic out_stall;
  pidci_pkg::out_req_t out_data;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pid_step_tracker tracker = new();
  int sender_idle;
  int receiver_stall;
  int sent;
  int settings;

  pid_with_conditional_integration #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  always #5 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall);
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  function automatic logic signed [23:0] rand_field();
    logic signed [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      default: return v >>> $urandom_range(23);
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    logic signed [31:0] g;
    g = $urandom;
    return g >>> $urandom_range(31);
  endfunction

  // one request, with a random gap ahead of it
  task automatic send_request(logic [1:0] cmd, logic signed [23:0] meas,
                              logic signed [23:0] target, logic signed [23:0] rate_in);
    pidci_pkg::in_req_t req;
    req.cmd = cmd;
    req.measured = meas;
    req.setpoint = target;
    req.external_rate = rate_in;
    case (sent * 3 / TOTAL_ITEMS)
      0: begin
        sender_idle = 23;
        receiver_stall = 60;
      end
      1: begin
        sender_idle = 60;
        receiver_stall = 23;
      end
      default: begin
        sender_idle = 0;
        receiver_stall = 0;
      end
    endcase
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    tracker.record_request(req);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_drives.size() != 0) @(negedge clk);
  endtask

  // apb write: setup then access, done at the edge with pready
  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    tracker.set_register(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                logic [15:0] period, logic [15:0] rate,
                                logic [22:0] olim, logic sel, logic [22:0] rlim);
    wait_idle();
    write_register(pidci_pkg::REG_KP, kp);
    write_register(pidci_pkg::REG_KI, ki);
    write_register(pidci_pkg::REG_KD, kd);
    write_register(pidci_pkg::REG_PERIOD, {16'd0, period});
    write_register(pidci_pkg::REG_RATE, {16'd0, rate});
    write_register(pidci_pkg::REG_OUT_LIM, {9'd0, olim});
    write_register(pidci_pkg::REG_RATE_SEL, {31'd0, sel});
    write_register(pidci_pkg::REG_REARM_LIM, {9'd0, rlim});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  // long run of full-scale error of one sign, drives the integral into saturation
  task automatic push_run(int len);
    logic signed [23:0] target;
    target = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
    repeat (len) send_request(pidci_pkg::CMD_STEP, ~target ^ 24'($urandom_range(255)),
                              target, rand_field());
  endtask

  task automatic run_block(int count, int push_max);
    int stop, kind, len;
    logic signed [23:0] target, meas;
    stop = sent + count;
    while (sent < stop) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        // tracking run: measurement closes in on a held reference
        len = $urandom_range(30, 3);
        target = rand_field();
        meas = rand_field();
        repeat (len) begin
          meas = meas + ((target - meas) >>> 2) + (rand_field() >>> 10);
          send_request(($urandom_range(19) == 0) ? pidci_pkg::CMD_REARM
                                                 : pidci_pkg::CMD_STEP,
                       meas, target, rand_field());
        end
      end else if (kind == 6) begin
        // reference crossing zero both ways
        target = rand_field();
        send_request(pidci_pkg::CMD_STEP, rand_field(), target, rand_field());
        send_request(pidci_pkg::CMD_STEP, rand_field(), -target, rand_field());
        send_request(pidci_pkg::CMD_STEP, rand_field(), 24'sd0, rand_field());
        send_request(pidci_pkg::CMD_STEP, rand_field(), target, rand_field());
      end else if (kind == 7) begin
        send_request($urandom_range(1) ? pidci_pkg::CMD_REARM : pidci_pkg::CMD_CLEAR,
                     rand_field(), rand_field(), rand_field());
      end else if (kind == 8) begin
        // noise, any command code
        send_request(2'($urandom_range(3)), rand_field(), rand_field(), rand_field());
      end else begin
        push_run($urandom_range(push_max, 10));
      end
    end
  endtask

  // main sequence
  initial begin
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    sender_idle = 23;
    receiver_stall = 60;
    sent = 0;
    settings = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: unit kp, tight output bound, small rearm clamp
    apply_settings(32'h0001_0000, 32'h0000_4000, 32'h0000_1000, 16'd655, 16'd100,
                   23'h10_0000, 1'b0, 23'h08_0000);
    send_request(pidci_pkg::CMD_STEP, 24'sh800000, 24'sh7FFFFF, 24'sh000000);
    send_request(pidci_pkg::CMD_STEP, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send_request(pidci_pkg::CMD_STEP, 24'sh000000, 24'sh000000, 24'sh800000);
    send_request(pidci_pkg::CMD_STEP, 24'sh000000, 24'sh000001, 24'sh000000);
    send_request(pidci_pkg::CMD_STEP, 24'sh000400, 24'shFFFFFF, 24'sh000000);
    send_request(pidci_pkg::CMD_REARM, 24'sh123456, 24'sh000000, 24'sh000000);
    send_request(pidci_pkg::CMD_STEP, 24'sh100000, 24'sh200000, 24'sh000000);
    send_request(pidci_pkg::CMD_STEP, 24'sh100000, 24'sh200000, 24'sh000000);
    send_request(CMD_UNUSED, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_request(pidci_pkg::CMD_REARM, 24'sh800000, 24'sh800000, 24'sh800000);
    send_request(pidci_pkg::CMD_CLEAR, 24'sh555555, 24'shAAAAAA, 24'sh555555);
    send_request(pidci_pkg::CMD_STEP, 24'sh400000, 24'shC00000, 24'sh000000);
    send_request(pidci_pkg::CMD_REARM, 24'sh000000, 24'sh000000, 24'sh000000);
    send_request(pidci_pkg::CMD_STEP, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh000000);

    // directed: derivative from the external rate, zero rearm clamp
    apply_settings(32'h0001_0000, 32'h0000_4000, 32'h0001_0000, 16'd655, 16'd100,
                   pidci_pkg::LIMIT_RST, 1'b1, 23'd0);
    send_request(pidci_pkg::CMD_STEP, 24'sh000000, 24'sh001000, 24'sh7FFFFF);
    send_request(pidci_pkg::CMD_STEP, 24'sh000000, 24'sh001000, 24'sh800000);
    send_request(pidci_pkg::CMD_STEP, 24'sh000000, 24'sh001000, 24'sh000000);
    send_request(pidci_pkg::CMD_REARM, 24'sh7FFFFF, 24'sh000000, 24'sh000000);
    send_request(pidci_pkg::CMD_STEP, 24'sh000000, 24'sh000000, 24'sh000000);

    // random blocks, one register setting each
    for (int b = 0; b < BLOCKS; b++) begin
      case (b)
        1: apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF,
                          pidci_pkg::LIMIT_RST, 1'b1, pidci_pkg::LIMIT_RST);
        2: apply_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'h0000,
                          23'd0, 1'b0, 23'd0);
        3: apply_settings(32'd0, 32'($urandom_range(255, 1)), 32'd0, 16'hFFFF,
                          16'($urandom), pidci_pkg::LIMIT_RST, 1'b0, pidci_pkg::LIMIT_RST);
        default: apply_settings(rand_gain(), rand_gain(), rand_gain(),
                                16'($urandom) >> $urandom_range(15),
                                16'($urandom) >> $urandom_range(15),
                                23'($urandom) >> $urandom_range(22), 1'($urandom_range(1)),
                                23'($urandom) >> $urandom_range(22));
      endcase
      if (b == 3) begin
        push_run(WINDUP_PUSH);
        run_block(BLOCK_ITEMS - WINDUP_PUSH, 300);
      end else begin
        run_block(BLOCK_ITEMS, 40);
      end
    end

    // drain and let any stray result show up
    wait_idle();
    repeat (40) @(negedge clk);
    $display("sent %0d requests: %0d steps, %0d rearm, %0d clear, %0d unused code",
             sent, tracker.steps, tracker.rearms, tracker.clears, tracker.unused);
    $display("%0d register settings, %0d results checked, %0d limit undos, %0d mismatches",
             settings, tracker.checked, tracker.hits, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_drives.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", tracker.pending_drives.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

[pid_with_conditional_integration.f]
design/pidci_pkg.sv
design/pid_with_conditional_integration.sv
design/pidci_checker.sv
tb/sv/tb_pid_with_conditional_integration.sv
